/* rtl/etsb_pkg.sv */
`default_nettype none

package etsb_pkg;

  localparam int NodeBits   = 8;
  localparam int BucketWays = 8;
  localparam int NumBuckets = (2 << NodeBits) - 1;
  localparam int NumEntries = NumBuckets * BucketWays;
  localparam int BucketW    = $clog2(NumBuckets);
  localparam int EntryAw    = $clog2(NumEntries);
  localparam int FillW      = $clog2(BucketWays + 1);
  localparam int NodesW     = 2 * NodeBits;
  localparam int ValW       = 31;
  localparam int LimitW     = 12;
  localparam int CountW     = 13;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(4088);

  typedef enum logic [1:0] {
    ActAdd     = 2'd0,
    ActRdFlow  = 2'd1,
    ActRdCap   = 2'd2,
    ActSetFlow = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup,
    StScan
  } state_e;

  typedef struct packed {
    action_e           action;
    logic [7:0]        node_from;
    logic [7:0]        node_to;
    logic [ValW-1:0]   capacity_in;
    logic [ValW-1:0]   flow_in;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [ValW-1:0]   flow_out;
    logic [ValW-1:0]   capacity_out;
    logic              table_full;
    logic              bucket_overflow;
  } result_t;

  typedef struct packed {
    logic [NodesW-1:0] nodes;
    logic [ValW-1:0]   capacity;
    logic [ValW-1:0]   flow;
  } entry_t;

  function automatic logic [EntryAw-1:0] entry_addr(logic [BucketW-1:0] bucket,
                                                    logic [FillW-1:0] way);
    return EntryAw'(bucket) * EntryAw'(BucketWays) + EntryAw'(way);
  endfunction

  function automatic logic [BucketW-1:0] bucket_of(logic [7:0] node_from,
                                                   logic [7:0] node_to);
    return BucketW'(node_from[NodeBits-1:0]) + BucketW'(node_to[NodeBits-1:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/etsb_fill_store.sv */
`default_nettype none

module etsb_fill_store import etsb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [BucketW-1:0] waddr_i,
  input  wire logic [FillW-1:0]   wdata_i,
  input  wire logic [BucketW-1:0] raddr_i,
  output logic      [FillW-1:0]   rdata_o
);

  logic [FillW-1:0] mem_q [NumBuckets];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/etsb_entry_store.sv */
`default_nettype none

module etsb_entry_store import etsb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [EntryAw-1:0] waddr_i,
  input  wire entry_t             wdata_i,
  input  wire logic [EntryAw-1:0] raddr_i,
  output entry_t                  rdata_o
);

  entry_t mem_q [NumEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/etsb_match.sv */
`default_nettype none

module etsb_match import etsb_pkg::*; (
  input  wire logic [NodesW-1:0] nodes_i,
  input  wire logic [7:0]        node_from_i,
  input  wire logic [7:0]        node_to_i,
  input  wire action_e           action_i,
  output logic                   match_o
);

  logic [NodeBits-1:0] src;
  logic [NodeBits-1:0] dst;
  logic [NodeBits-1:0] key_from;
  logic [NodeBits-1:0] key_to;

  assign src      = nodes_i[NodesW-1:NodeBits];
  assign dst      = nodes_i[NodeBits-1:0];
  assign key_from = node_from_i[NodeBits-1:0];
  assign key_to   = node_to_i[NodeBits-1:0];

  // Set-flow hits every entry whose source is either node, covering both directions.
  always_comb begin
    case (action_i)
      ActSetFlow: match_o = (src == key_from) || (src == key_to);
      default:    match_o = (src == key_from) && (dst == key_to);
    endcase
  end

endmodule

`default_nettype wire

/* rtl/edge_table_sum_bucket.sv */
`default_nettype none

// An add, or a read or set-flow on an empty bucket, is answered from the lookup state; any other
// read or set-flow then scans the bucket's fill entries, fill being the bucket's entry count
// (1 to 8), scanned one entry per cycle. busy_o drops in the done_o cycle, so no item is taken
// before the last one is done; the receiver cannot stall. After reset busy_o is high while the
// bucket fill memory is cleared; reset is asynchronous and active low. Configuration is taken
// any time.
module edge_table_sum_bucket import etsb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire item_t             item_i,
  output logic                   done_o,
  output result_t                result_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [LimitW-1:0] cfg_data_i
);

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  logic [BucketW-1:0]  bucket_q, bucket_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [FillW-1:0]    idx_q, idx_d;
  logic                chk_q, chk_d;
  logic [EntryAw-1:0]  chk_addr_q, chk_addr_d;
  logic                found_q, found_d;
  logic [ValW-1:0]     flow_q, flow_d;
  logic [ValW-1:0]     cap_q, cap_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [LimitW-1:0]   limit_q;
  logic [BucketW-1:0]  clr_idx_q, clr_idx_d;
  logic                done_q, done_d;
  result_t             res_q, res_d;

  logic                fill_we;
  logic [BucketW-1:0]  fill_waddr;
  logic [FillW-1:0]    fill_wdata;
  logic [FillW-1:0]    fill_rdata;
  logic [FillW-1:0]    fill_eff;
  logic                ent_we;
  logic [EntryAw-1:0]  ent_waddr;
  entry_t              ent_wdata;
  logic [EntryAw-1:0]  ent_raddr;
  entry_t              ent_rdata;
  logic                hit;
  logic                issue;
  logic                clr_last;

  assign busy_o      = (state_q != StIdle);
  assign done_o      = done_q;
  assign result_o    = res_q;
  assign cfg_ready_o = 1'b1;

  assign fill_eff  = (fill_rdata > FillW'(BucketWays)) ? FillW'(BucketWays) : fill_rdata;
  assign issue     = (idx_q < fill_q);
  assign ent_raddr = entry_addr(bucket_q, idx_q);
  assign clr_last  = (clr_idx_q == BucketW'(NumBuckets - 1));

  etsb_fill_store u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (bucket_of(item_i.node_from, item_i.node_to)),
    .rdata_o (fill_rdata)
  );

  etsb_entry_store u_entry (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  etsb_match u_match (
    .nodes_i     (ent_rdata.nodes),
    .node_from_i (item_q.node_from),
    .node_to_i   (item_q.node_to),
    .action_i    (item_q.action),
    .match_o     (hit)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (item_q.action == ActAdd || fill_eff == '0) begin
          state_d = StIdle;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (!issue && chk_q) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    bucket_d   = bucket_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    chk_d      = 1'b0;
    chk_addr_d = chk_addr_q;
    found_d    = found_q;
    flow_d     = flow_q;
    cap_d      = cap_q;
    count_d    = count_q;
    clr_idx_d  = clr_idx_q;
    done_d     = 1'b0;
    res_d      = res_q;
    fill_we    = 1'b0;
    fill_waddr = bucket_q;
    fill_wdata = fill_eff + FillW'(1);
    ent_we     = 1'b0;
    ent_waddr  = entry_addr(bucket_q, fill_eff);
    ent_wdata  = '{nodes: {item_q.node_from[NodeBits-1:0], item_q.node_to[NodeBits-1:0]},
                   capacity: item_q.capacity_in, flow: item_q.flow_in};
    case (state_q)
      StClear: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx_q;
        fill_wdata = '0;
        clr_idx_d  = clr_idx_q + BucketW'(1);
      end
      StIdle: begin
        if (start_i) begin
          item_d   = item_i;
          bucket_d = bucket_of(item_i.node_from, item_i.node_to);
          idx_d    = '0;
          found_d  = 1'b0;
          flow_d   = '0;
          cap_d    = '0;
        end
      end
      StLookup: begin
        fill_d = fill_eff;
        if (item_q.action == ActAdd) begin
          if (fill_eff < FillW'(BucketWays)) begin
            ent_we  = 1'b1;
            fill_we = 1'b1;
            count_d = count_q + CountW'(1);
          end
          done_d = 1'b1;
          res_d  = '{found: 1'b0, flow_out: '0, capacity_out: '0,
                     table_full: (count_d == CountW'(limit_q)),
                     bucket_overflow: (fill_eff >= FillW'(BucketWays))};
        end else if (fill_eff == '0) begin
          done_d = 1'b1;
          res_d  = '{found: 1'b0, flow_out: '0, capacity_out: '0,
                     table_full: (count_q == CountW'(limit_q)), bucket_overflow: 1'b0};
        end
      end
      StScan: begin
        // One entry is read per cycle; its data is checked in the following cycle.
        if (issue) begin
          idx_d = idx_q + FillW'(1);
        end
        chk_d      = issue;
        chk_addr_d = ent_raddr;
        if (chk_q && hit) begin
          found_d = 1'b1;
          case (item_q.action)
            ActRdFlow: begin
              if (!found_q) begin
                flow_d = ent_rdata.flow;
              end
            end
            ActRdCap: cap_d = ent_rdata.capacity;
            ActSetFlow: begin
              ent_we    = 1'b1;
              ent_waddr = chk_addr_q;
              ent_wdata = '{nodes: ent_rdata.nodes, capacity: ent_rdata.capacity,
                            flow: item_q.flow_in};
            end
            default: ;
          endcase
        end
        if (!issue && chk_q) begin
          done_d = 1'b1;
          res_d  = '{found: found_d, flow_out: flow_d, capacity_out: cap_d,
                     table_full: (count_q == CountW'(limit_q)), bucket_overflow: 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_idx_q <= '0;
      count_q   <= '0;
      limit_q   <= LimitReset;
      done_q    <= 1'b0;
      chk_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      count_q   <= count_d;
      done_q    <= done_d;
      chk_q     <= chk_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    bucket_q   <= bucket_d;
    fill_q     <= fill_d;
    idx_q      <= idx_d;
    chk_addr_q <= chk_addr_d;
    found_q    <= found_d;
    flow_q     <= flow_d;
    cap_q      <= cap_d;
    res_q      <= res_d;
  end

endmodule

`default_nettype wire

/* dv/edge_table_sum_bucket_tb.sv */
`timescale 1ns / 100ps

module edge_table_sum_bucket_tb import etsb_pkg::*;;

  localparam int CycleLimit = 400_000;
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  item_t             item_i;
  logic              done_o;
  result_t           result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i;

  edge_table_sum_bucket dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the edge table.
  logic [FillW-1:0]  shadow_fill [NumBuckets];
  logic [NodesW-1:0] shadow_nodes [NumEntries];
  logic [ValW-1:0]   shadow_cap [NumEntries];
  logic [ValW-1:0]   shadow_flow [NumEntries];
  logic [CountW-1:0] shadow_edges;
  logic [LimitW-1:0] shadow_limit;

  item_t       pending_ops [$];
  result_t     expected_replies [$];
  int unsigned idle_pct;
  bit          hold_ops;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic result_t predict_table_op(item_t op);
    logic [NodeBits-1:0] src;
    logic [NodeBits-1:0] dst;
    logic [NodeBits-1:0] owner;
    int unsigned bucket;
    int unsigned base;
    int unsigned fill;
    int unsigned i;
    result_t r;
    src = op.node_from[NodeBits-1:0];
    dst = op.node_to[NodeBits-1:0];
    bucket = src + dst;
    base = bucket * BucketWays;
    fill = shadow_fill[bucket];
    r = '0;
    case (op.action)
      ActAdd: begin
        if (fill >= BucketWays) begin
          r.bucket_overflow = 1'b1;
        end else begin
          shadow_nodes[base + fill] = {src, dst};
          shadow_cap[base + fill] = op.capacity_in;
          shadow_flow[base + fill] = op.flow_in;
          shadow_fill[bucket] = FillW'(fill + 1);
          shadow_edges = shadow_edges + 1'b1;
        end
      end
      ActRdFlow: begin
        // The first matching entry wins.
        for (i = 0; i < fill; i++) begin
          if (shadow_nodes[base + i] == {src, dst}) begin
            r.found = 1'b1;
            r.flow_out = shadow_flow[base + i];
            break;
          end
        end
      end
      ActRdCap: begin
        // The last matching entry wins.
        for (i = 0; i < fill; i++) begin
          if (shadow_nodes[base + i] == {src, dst}) begin
            r.found = 1'b1;
            r.capacity_out = shadow_cap[base + i];
          end
        end
      end
      ActSetFlow: begin
        // Both directions share the bucket, so match the source against either node.
        for (i = 0; i < fill; i++) begin
          owner = shadow_nodes[base + i][NodesW-1:NodeBits];
          if (owner == src || owner == dst) begin
            r.found = 1'b1;
            shadow_flow[base + i] = op.flow_in;
          end
        end
      end
      default: begin
      end
    endcase
    r.table_full = (shadow_edges == CountW'(shadow_limit));
    return r;
  endfunction

  function automatic item_t make_op(action_e act, int unsigned from_node, int unsigned to_node,
                                    logic [ValW-1:0] cap, logic [ValW-1:0] flow);
    item_t op;
    op.action = act;
    op.node_from = 8'(from_node);
    op.node_to = 8'(to_node);
    op.capacity_in = cap;
    op.flow_in = flow;
    return op;
  endfunction

  function automatic logic [ValW-1:0] random_value();
    if ($urandom_range(9) == 0) begin
      return ($urandom_range(1) == 1) ? ValMax : '0;
    end
    return ValW'($urandom);
  endfunction

  // Most operations land in a small cluster of nodes so that buckets fill up,
  // reads hit and adds overflow; the rest are spread over the whole node range.
  function automatic item_t random_op(int unsigned pool);
    int unsigned roll;
    int unsigned shape;
    item_t op;
    roll = $urandom_range(99);
    shape = $urandom_range(99);
    if (roll < 38) begin
      op.action = ActAdd;
    end else if (roll < 58) begin
      op.action = ActRdFlow;
    end else if (roll < 78) begin
      op.action = ActRdCap;
    end else begin
      op.action = ActSetFlow;
    end
    if (shape < 80) begin
      op.node_from = 8'(pool + $urandom_range(7));
      op.node_to = 8'(pool + $urandom_range(7));
    end else if (shape < 90) begin
      op.node_from = 8'($urandom);
      op.node_to = 8'($urandom);
    end else begin
      op.node_from = 8'($urandom_range(248, 255));
      op.node_to = 8'($urandom_range(248, 255));
    end
    op.capacity_in = random_value();
    op.flow_in = random_value();
    return op;
  endfunction

  // Sends one config word and updates the shadow limit at its handshake.
  task automatic write_limit(input logic [LimitW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_limit = value;
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || start_i || expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns %s: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // An operation word is taken when start is high and busy is low; start then
  // stays up with the same word until it is taken.
  always @(posedge clk_i) begin : drive_ops
    bit taken;
    taken = rst_ni && start_i && !busy_o;
    if (taken) begin
      void'(pending_ops.pop_front());
      expected_replies.push_back(predict_table_op(item_i));
    end
    if (start_i && !taken) begin
      start_i <= 1'b1;
    end else if (!hold_ops && pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start_i <= 1'b1;
      item_i <= pending_ops[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_replies
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        $display("%0t ns unexpected result: expected none actual %h", $time, result_o);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        check_field("found", 32'(want.found), 32'(result_o.found));
        check_field("flow_out", 32'(want.flow_out), 32'(result_o.flow_out));
        check_field("capacity_out", 32'(want.capacity_out), 32'(result_o.capacity_out));
        check_field("table_full", 32'(want.table_full), 32'(result_o.table_full));
        check_field("bucket_overflow", 32'(want.bucket_overflow),
                    32'(result_o.bucket_overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned pool;
    int unsigned k;
    logic [LimitW-1:0] limit_word;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    hold_ops = 1'b1;
    idle_pct = 22;
    mismatches = 0;
    cycle_cnt = 0;
    shadow_edges = '0;
    shadow_limit = LimitReset;
    for (k = 0; k < NumBuckets; k++) shadow_fill[k] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A zero limit makes the empty table read as full.
    write_limit('0);
    hold_ops = 1'b0;

    pending_ops.push_back(make_op(ActRdFlow, 3, 5, '0, '0));
    pending_ops.push_back(make_op(ActRdCap, 3, 5, '0, '0));
    pending_ops.push_back(make_op(ActSetFlow, 3, 5, '0, 31'd7));
    pending_ops.push_back(make_op(ActAdd, 3, 5, ValMax, '0));
    pending_ops.push_back(make_op(ActAdd, 3, 5, '0, ValMax));
    pending_ops.push_back(make_op(ActAdd, 5, 3, 31'd123, 31'd456));
    pending_ops.push_back(make_op(ActRdFlow, 3, 5, '0, '0));
    pending_ops.push_back(make_op(ActRdCap, 3, 5, '0, '0));
    pending_ops.push_back(make_op(ActSetFlow, 5, 3, ValMax, 31'h2AAA_AAAA));
    pending_ops.push_back(make_op(ActRdFlow, 3, 5, '0, '0));
    pending_ops.push_back(make_op(ActRdCap, 5, 3, '0, '0));
    pending_ops.push_back(make_op(ActAdd, 255, 255, ValMax, ValMax));
    pending_ops.push_back(make_op(ActRdCap, 255, 255, '0, '0));
    pending_ops.push_back(make_op(ActRdFlow, 0, 255, '0, '0));
    pending_ops.push_back(make_op(ActAdd, 0, 0, 31'd1, 31'd1));
    pending_ops.push_back(make_op(ActSetFlow, 0, 0, '0, 31'h5555_5555));
    // Nine adds into one bucket: the last one finds it full.
    for (k = 0; k < 9; k++) begin
      pending_ops.push_back(make_op(ActAdd, k, 9 - k, ValW'(k), ValW'(k + 100)));
    end
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: limit_word = '1;
        1: limit_word = LimitW'(shadow_edges + 10);
        2: limit_word = LimitW'(shadow_edges + 3);
        3: limit_word = '0;
        4: limit_word = LimitW'(shadow_edges + 25);
        default: limit_word = LimitW'(shadow_edges);
      endcase
      write_limit(limit_word);
      idle_pct = (ph == 1) ? 0 : 22;
      pool = $urandom_range(248);
      repeat (290) pending_ops.push_back(random_op(pool));
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
